### hdl/nonpreemptive_priority_scheduler_unit_macros.svh
// assertion macros for the priority scheduler
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define NPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// antecedent holds in this cycle, consequent in the next one
`define NPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### hdl/nps_pkg.sv
// types and constants shared by the scheduler cells and top level
`default_nettype none

package nps_pkg;

  localparam int PrioW = 8;
  localparam int ArrW  = 16;
  localparam int BstW  = 16;
  localparam int PidW  = 6;
  localparam int TimeW = 23;
  localparam int SumW  = 30;

  typedef struct packed {
    logic [PrioW-1:0] priority_req;
    logic [ArrW-1:0]  arrival;
    logic [BstW-1:0]  burst;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [PidW-1:0]  pid;
    logic [ArrW-1:0]  arrival_out;
    logic [BstW-1:0]  burst_out;
    logic [TimeW-1:0] completion;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [SumW-1:0]  total_turnaround;
    logic [SumW-1:0]  total_waiting;
    logic             final_res;
  } out_item_t;

  typedef enum logic [0:0] {
    MODE_SCHED = 1'b0,
    MODE_EMIT  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_LOAD       = 3'd0,
    ST_SCHED_GO   = 3'd1,
    ST_SCHED_WAIT = 3'd2,
    ST_EMIT_GO    = 3'd3,
    ST_EMIT_WAIT  = 3'd4,
    ST_EMIT_PUSH  = 3'd5
  } state_e;

  // search token passed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [PrioW-1:0] prio;
    logic [ArrW-1:0]  arr;
    logic [BstW-1:0]  bst;
    logic [TimeW-1:0] fin;
    logic [PidW-1:0]  idx;
    logic             nxt_found;
    logic [ArrW-1:0]  nxt_arr;
  } token_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] cur_time;
    logic             first;
    logic [TimeW-1:0] last_fin;
    logic [PidW-1:0]  last_idx;
    logic             commit;
    logic [PidW-1:0]  commit_idx;
    logic [TimeW-1:0] commit_fin;
    logic             clear;
  } bcast_t;

endpackage

`default_nettype wire

### hdl/nps_cell.sv
// one process slot of the scheduler chain with its search stage
`default_nettype none

module nps_cell #(
  parameter int MAX_PROCS = 32,
  parameter int CELL_IDX  = 0,
  localparam int CntW = $clog2(MAX_PROCS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CntW-1:0]   count_i,
  input  wire logic              load_i,
  input  var  nps_pkg::in_item_t rec_i,
  input  var  nps_pkg::bcast_t   bc_i,
  input  var  nps_pkg::token_t   tok_i,
  output nps_pkg::token_t        tok_o
);

  logic [nps_pkg::PrioW-1:0] prio_q;
  logic [nps_pkg::ArrW-1:0]  arr_q;
  logic [nps_pkg::BstW-1:0]  bst_q;
  logic [nps_pkg::TimeW-1:0] fin_q;
  logic                      done_q;
  logic                      done_d;
  logic                      loaded;
  logic                      mine;
  logic                      after_last;
  logic [nps_pkg::PidW-1:0]  own_idx;
  nps_pkg::token_t           tok_d;
  nps_pkg::token_t           tok_q;
  logic                      tok_vld_q;

  assign own_idx = nps_pkg::PidW'(CELL_IDX);
  assign loaded  = CntW'(CELL_IDX) < count_i;
  assign mine    = bc_i.commit && (bc_i.commit_idx == own_idx);
  assign after_last = bc_i.first || (fin_q > bc_i.last_fin) ||
                      ((fin_q == bc_i.last_fin) && (own_idx > bc_i.last_idx));

  always_comb begin
    tok_d = tok_i;
    case (bc_i.mode)
      nps_pkg::MODE_SCHED: begin
        if (loaded && !done_q) begin
          if (nps_pkg::TimeW'(arr_q) > bc_i.cur_time) begin
            if (!tok_i.nxt_found || (arr_q < tok_i.nxt_arr)) begin
              tok_d.nxt_found = 1'b1;
              tok_d.nxt_arr   = arr_q;
            end
          end else if (!tok_i.found || (prio_q < tok_i.prio) ||
                       ((prio_q == tok_i.prio) && (arr_q < tok_i.arr))) begin
            tok_d.found = 1'b1;
            tok_d.prio  = prio_q;
            tok_d.arr   = arr_q;
            tok_d.bst   = bst_q;
            tok_d.idx   = own_idx;
          end
        end
      end
      nps_pkg::MODE_EMIT: begin
        if (loaded && after_last && (!tok_i.found || (fin_q < tok_i.fin))) begin
          tok_d.found = 1'b1;
          tok_d.arr   = arr_q;
          tok_d.bst   = bst_q;
          tok_d.fin   = fin_q;
          tok_d.idx   = own_idx;
        end
      end
      default: begin
        tok_d = tok_i;
      end
    endcase
  end

  always_comb begin
    done_d = done_q;
    if (bc_i.clear) begin
      done_d = 1'b0;
    end else if (mine) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      tok_vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (load_i && (count_i == CntW'(CELL_IDX))) begin
      prio_q <= rec_i.priority_req;
      arr_q  <= rec_i.arrival;
      bst_q  <= rec_i.burst;
    end
    if (mine) begin
      fin_q <= bc_i.commit_fin;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

`default_nettype wire

### hdl/nonpreemptive_priority_scheduler_unit.sv
// Non-preemptive priority scheduler. Process records (priority, arrival,
// burst) are taken one per cycle into a chain of MAX_PROCS cells; a record
// arriving while the chain is full is dropped. The record marked last
// starts the schedule and input stalls until the batch is out. Every
// scheduling decision (one per process, plus one per idle jump to the next
// arrival) is a search token walking the whole chain. Results then leave
// in completion order, ties by load index, one chain walk each, the next
// walk overlapping a result that waits on out_stall_i. The final result
// carries the turnaround and waiting totals; the counters, time, totals
// and cell done flags then clear for the next batch.
`default_nettype none
`include "nonpreemptive_priority_scheduler_unit_macros.svh"

module nonpreemptive_priority_scheduler_unit #(
  parameter int MAX_PROCS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  var  nps_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output nps_pkg::out_item_t      out_data_o
);

  localparam int CntW = $clog2(MAX_PROCS + 1);

  nps_pkg::state_e           state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           done_cnt_q, done_cnt_d;
  logic [CntW-1:0]           sent_cnt_q, sent_cnt_d;
  logic [nps_pkg::TimeW-1:0] cur_time_q, cur_time_d;
  logic [nps_pkg::SumW-1:0]  sum_ta_q, sum_ta_d;
  logic [nps_pkg::SumW-1:0]  sum_wt_q, sum_wt_d;
  logic [nps_pkg::TimeW-1:0] last_fin_q, last_fin_d;
  logic [nps_pkg::PidW-1:0]  last_idx_q, last_idx_d;
  nps_pkg::out_item_t        res_q, res_d;
  nps_pkg::out_item_t        out_q, out_d;
  logic                      out_vld_q, out_vld_d;

  nps_pkg::token_t           tok [MAX_PROCS+1];
  nps_pkg::token_t           tail;
  nps_pkg::bcast_t           bc;
  nps_pkg::mode_e            mode_sel;
  logic                      in_take;
  logic                      load_en;
  logic                      full;
  logic                      scan_start;
  logic                      out_free;
  logic                      sched_hit;
  logic                      emit_hit;
  logic                      batch_end;
  logic [nps_pkg::TimeW-1:0] wt_amt;
  logic [nps_pkg::TimeW-1:0] fin_new;
  logic [nps_pkg::TimeW-1:0] ta_emit;
  logic                      last_emit;
  logic                      walk_wait;
  logic                      batch_idle;

  assign tail      = tok[MAX_PROCS];
  assign full      = count_q == CntW'(MAX_PROCS);
  assign in_take   = in_valid_i && !in_stall_o;
  assign load_en   = in_take && !full;
  assign out_free  = !out_vld_q || !out_stall_i;
  assign sched_hit = (state_q == nps_pkg::ST_SCHED_WAIT) && tail.vld;
  assign emit_hit  = (state_q == nps_pkg::ST_EMIT_WAIT) && tail.vld;
  assign batch_end = (state_q == nps_pkg::ST_EMIT_PUSH) && out_free && res_q.final_res;
  assign last_emit = (sent_cnt_q + CntW'(1)) == count_q;

  assign wt_amt  = cur_time_q - nps_pkg::TimeW'(tail.arr);
  assign fin_new = cur_time_q + nps_pkg::TimeW'(tail.bst);
  assign ta_emit = tail.fin - nps_pkg::TimeW'(tail.arr);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nps_pkg::ST_LOAD: begin
        if (in_take && in_data_i.last) begin
          state_d = nps_pkg::ST_SCHED_GO;
        end
      end
      nps_pkg::ST_SCHED_GO: begin
        state_d = nps_pkg::ST_SCHED_WAIT;
      end
      nps_pkg::ST_SCHED_WAIT: begin
        if (tail.vld) begin
          if (tail.found && ((done_cnt_q + CntW'(1)) == count_q)) begin
            state_d = nps_pkg::ST_EMIT_GO;
          end else begin
            state_d = nps_pkg::ST_SCHED_GO;
          end
        end
      end
      nps_pkg::ST_EMIT_GO: begin
        state_d = nps_pkg::ST_EMIT_WAIT;
      end
      nps_pkg::ST_EMIT_WAIT: begin
        if (tail.vld) begin
          state_d = nps_pkg::ST_EMIT_PUSH;
        end
      end
      nps_pkg::ST_EMIT_PUSH: begin
        if (out_free) begin
          state_d = res_q.final_res ? nps_pkg::ST_LOAD : nps_pkg::ST_EMIT_GO;
        end
      end
      default: begin
        state_d = nps_pkg::ST_LOAD;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    scan_start = 1'b0;
    mode_sel   = nps_pkg::MODE_SCHED;
    case (state_q)
      nps_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
      end
      nps_pkg::ST_SCHED_GO: begin
        scan_start = 1'b1;
      end
      nps_pkg::ST_SCHED_WAIT: begin
        mode_sel = nps_pkg::MODE_SCHED;
      end
      nps_pkg::ST_EMIT_GO: begin
        scan_start = 1'b1;
        mode_sel   = nps_pkg::MODE_EMIT;
      end
      nps_pkg::ST_EMIT_WAIT: begin
        mode_sel = nps_pkg::MODE_EMIT;
      end
      nps_pkg::ST_EMIT_PUSH: begin
        mode_sel = nps_pkg::MODE_EMIT;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    bc.mode       = mode_sel;
    bc.cur_time   = cur_time_q;
    bc.first      = sent_cnt_q == '0;
    bc.last_fin   = last_fin_q;
    bc.last_idx   = last_idx_q;
    bc.commit     = sched_hit && tail.found;
    bc.commit_idx = tail.idx;
    bc.commit_fin = fin_new;
    bc.clear      = batch_end;
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = scan_start;
  end

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    nps_cell #(
      .MAX_PROCS(MAX_PROCS),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .count_i(count_q),
      .load_i (load_en),
      .rec_i  (in_data_i),
      .bc_i   (bc),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // datapath next values
  always_comb begin
    count_d    = count_q;
    done_cnt_d = done_cnt_q;
    sent_cnt_d = sent_cnt_q;
    cur_time_d = cur_time_q;
    sum_ta_d   = sum_ta_q;
    sum_wt_d   = sum_wt_q;
    last_fin_d = last_fin_q;
    last_idx_d = last_idx_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (load_en) begin
      count_d = count_q + CntW'(1);
    end

    if (sched_hit) begin
      if (tail.found) begin
        cur_time_d = fin_new;
        sum_wt_d   = sum_wt_q + nps_pkg::SumW'(wt_amt);
        sum_ta_d   = sum_ta_q + nps_pkg::SumW'(wt_amt) + nps_pkg::SumW'(tail.bst);
        done_cnt_d = done_cnt_q + CntW'(1);
      end else begin
        cur_time_d = nps_pkg::TimeW'(tail.nxt_arr);
      end
    end

    if (emit_hit) begin
      last_fin_d             = tail.fin;
      last_idx_d             = tail.idx;
      res_d.pid              = tail.idx;
      res_d.arrival_out      = tail.arr;
      res_d.burst_out        = tail.bst;
      res_d.completion       = tail.fin;
      res_d.turnaround       = ta_emit;
      res_d.waiting          = ta_emit - nps_pkg::TimeW'(tail.bst);
      res_d.total_turnaround = last_emit ? sum_ta_q : '0;
      res_d.total_waiting    = last_emit ? sum_wt_q : '0;
      res_d.final_res        = last_emit;
    end

    if ((state_q == nps_pkg::ST_EMIT_PUSH) && out_free) begin
      out_d      = res_q;
      out_vld_d  = 1'b1;
      sent_cnt_d = sent_cnt_q + CntW'(1);
    end

    if (batch_end) begin
      count_d    = '0;
      done_cnt_d = '0;
      sent_cnt_d = '0;
      cur_time_d = '0;
      sum_ta_d   = '0;
      sum_wt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nps_pkg::ST_LOAD;
      count_q    <= '0;
      done_cnt_q <= '0;
      sent_cnt_q <= '0;
      cur_time_q <= '0;
      sum_ta_q   <= '0;
      sum_wt_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      done_cnt_q <= done_cnt_d;
      sent_cnt_q <= sent_cnt_d;
      cur_time_q <= cur_time_d;
      sum_ta_q   <= sum_ta_d;
      sum_wt_q   <= sum_wt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_fin_q <= last_fin_d;
    last_idx_q <= last_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign walk_wait  = (state_q == nps_pkg::ST_SCHED_WAIT) ||
                      (state_q == nps_pkg::ST_EMIT_WAIT);
  assign batch_idle = (count_q == '0) && (sent_cnt_q == '0) &&
                      (state_q == nps_pkg::ST_LOAD);

  // a search token only comes back while its walk is awaited
  `NPS_ASSERT_IMPL(a_tail_when_waiting, clk_i, rst_ni, tail.vld, walk_wait)
  // a batch being worked on always holds at least one record
  `NPS_ASSERT_IMPL(a_batch_not_empty, clk_i, rst_ni, state_q != nps_pkg::ST_LOAD, count_q != '0)
  // every schedule search inside a batch finds a process or a later arrival
  `NPS_ASSERT_IMPL(a_sched_progress, clk_i, rst_ni, sched_hit, tail.found || tail.nxt_found)
  // the end of a batch leaves the counters cleared
  `NPS_ASSERT_NEXT(a_batch_clear, clk_i, rst_ni, batch_end, batch_idle)

endmodule

`default_nettype wire
